[sv/dtlv_pkg.sv]
`timescale 1ns / 1ps

package dtlv_pkg;

    localparam logic [4:0] TAG_LOW_MASK   = 5'h1f;
    localparam int         TAG_BITS       = 8;
    localparam int         LEN_BITS       = 32;
    localparam int         HSIZE_BITS     = 3;
    localparam int         STATUS_BITS    = 2;

    localparam logic [STATUS_BITS-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_BITS-1:0] ST_TRUNC   = 2'd1;
    localparam logic [STATUS_BITS-1:0] ST_BADFORM = 2'd2;
    localparam logic [STATUS_BITS-1:0] ST_TOOLONG = 2'd3;

    typedef enum logic [3:0] {
        PH_IDLE     = 4'b0001,
        PH_EXTTAG   = 4'b0010,
        PH_LENLEAD  = 4'b0100,
        PH_LENBYTES = 4'b1000
    } phase_t;

    typedef struct packed {
        logic [7:0]          data_byte;
        logic                first;
        logic [LEN_BITS-1:0] bytes_left;
    } item_t;

    typedef struct packed {
        logic [TAG_BITS-1:0]    tag_byte;
        logic [LEN_BITS-1:0]    value_length;
        logic [HSIZE_BITS-1:0]  header_size;
        logic [STATUS_BITS-1:0] status;
    } res_t;

endpackage

[sv/dtlv_if.sv]
`timescale 1ns / 1ps

interface dtlv_in_if;
    logic        valid;
    logic        ready;
    logic [7:0]  data_byte;
    logic        first;
    logic [31:0] bytes_left;

    modport source (output valid, output data_byte, output first, output bytes_left,
                    input ready);
    modport sink   (input valid, input data_byte, input first, input bytes_left,
                    output ready);
endinterface

interface dtlv_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  tag_byte;
    logic [31:0] value_length;
    logic [2:0]  header_size;
    logic [1:0]  status;

    modport source (output valid, output tag_byte, output value_length,
                    output header_size, output status, input ready);
    modport sink   (input valid, input tag_byte, input value_length,
                    input header_size, input status, output ready);
endinterface

[sv/der_tlv_header_parser.sv]
`timescale 1ns / 1ps

// der tlv header parser
// hdr_bytes: one header byte per request; first marks the identifier byte and
//   carries bytes_left, the bytes left in the enclosing region counting it
// result: one request per finished or failed header with tag_byte,
//   value_length, header_size and status (ok, truncated, bad length form,
//   length exceeds region)
// throughput: one byte per cycle while the result channel is not stalled;
//   the parser step between the input and result registers is combinational
// an accepted byte waits in the input register until the parser step takes
//   it; any result goes into the result register, which drives result
// a stray byte while idle gives no result; a new first byte drops any
//   header in progress
// reset clears both valid flags and the parser state to idle
// when result stalls, the result register holds; hdr_bytes takes one more
//   byte only if the input register is empty, then ready drops until the
//   result is taken
module der_tlv_header_parser
#(
    parameter int MAX_LEN_BYTES = 4
)
(
    input  logic        clk,
    input  logic        rst_n,
    dtlv_in_if.sink     hdr_bytes,
    dtlv_out_if.source  result
);

    dtlv_pkg::item_t in_item;
    dtlv_pkg::item_t item;
    dtlv_pkg::res_t  res;
    dtlv_pkg::res_t  out_res;
    logic            item_valid;
    logic            advance;
    logic            emit;

    assign in_item.data_byte  = hdr_bytes.data_byte;
    assign in_item.first      = hdr_bytes.first;
    assign in_item.bytes_left = hdr_bytes.bytes_left;

    dtlv_in_stage u_in
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (hdr_bytes.valid),
        .in_ready   (hdr_bytes.ready),
        .in_item    (in_item),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    dtlv_core #(.MAX_LEN_BYTES(MAX_LEN_BYTES)) u_core
    (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (advance),
        .item  (item),
        .emit  (emit),
        .res   (res)
    );

    dtlv_out_stage u_out
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .emit       (emit),
        .res        (res),
        .advance    (advance),
        .out_valid  (result.valid),
        .out_ready  (result.ready),
        .out_res    (out_res)
    );

    assign result.tag_byte     = out_res.tag_byte;
    assign result.value_length = out_res.value_length;
    assign result.header_size  = out_res.header_size;
    assign result.status       = out_res.status;

endmodule

[sv/dtlv_in_stage.sv]
`timescale 1ns / 1ps

module dtlv_in_stage
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  dtlv_pkg::item_t in_item,
    input  logic           advance,
    output logic           item_valid,
    output dtlv_pkg::item_t item
);

    logic            valid_reg;
    logic            valid_next;
    dtlv_pkg::item_t item_reg;

    // slot frees when its byte moves on to the parser this cycle
    assign in_ready = !valid_reg || advance;

    always_comb
    begin
        valid_next = valid_reg;
        if (in_ready)
        begin
            valid_next = in_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            item_reg <= in_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

[sv/dtlv_core.sv]
`timescale 1ns / 1ps

module dtlv_core
#(
    parameter int MAX_LEN_BYTES = 4
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            step,
    input  dtlv_pkg::item_t item,
    output logic            emit,
    output dtlv_pkg::res_t  res
);

    localparam int LBW = $clog2(MAX_LEN_BYTES + 1);

    dtlv_pkg::phase_t                      phase_reg,  phase_next;
    logic [dtlv_pkg::TAG_BITS-1:0]         tag_reg,    tag_next;
    logic [dtlv_pkg::LEN_BITS-1:0]         region_reg, region_next;
    logic [dtlv_pkg::LEN_BITS-1:0]         acc_reg,    acc_next;
    logic [LBW-1:0]                        lbl_reg,    lbl_next;
    logic [dtlv_pkg::HSIZE_BITS-1:0]       hc_reg,     hc_next;

    logic [dtlv_pkg::LEN_BITS-1:0]   region_dec;
    logic [dtlv_pkg::HSIZE_BITS-1:0] hc_inc;
    logic [6:0]                      lead_n;
    logic [7:0]                      b;

    assign b          = item.data_byte;
    assign region_dec = region_reg - 1'b1;
    assign hc_inc     = hc_reg + 1'b1;
    assign lead_n     = b[6:0];

    always_comb
    begin
        phase_next  = phase_reg;
        tag_next    = tag_reg;
        region_next = region_reg;
        acc_next    = acc_reg;
        lbl_next    = lbl_reg;
        hc_next     = hc_reg;
        emit        = 1'b0;
        res.tag_byte     = tag_reg;
        res.value_length = '0;
        res.header_size  = hc_reg;
        res.status       = dtlv_pkg::ST_TRUNC;

        if (step)
        begin
            if (item.first)
            begin
                acc_next = '0;
                lbl_next = '0;
                if (item.bytes_left == '0)
                begin
                    // empty region: byte not consumed
                    region_next     = '0;
                    tag_next        = '0;
                    hc_next         = '0;
                    phase_next      = dtlv_pkg::PH_IDLE;
                    emit            = 1'b1;
                    res.tag_byte    = '0;
                    res.header_size = '0;
                end
                else
                begin
                    region_next = item.bytes_left - 1'b1;
                    tag_next    = b;
                    hc_next     = dtlv_pkg::HSIZE_BITS'(1);
                    if (b[4:0] == dtlv_pkg::TAG_LOW_MASK)
                    begin
                        phase_next = dtlv_pkg::PH_EXTTAG;
                    end
                    else
                    begin
                        phase_next = dtlv_pkg::PH_LENLEAD;
                    end
                    if (item.bytes_left == dtlv_pkg::LEN_BITS'(1))
                    begin
                        phase_next      = dtlv_pkg::PH_IDLE;
                        emit            = 1'b1;
                        res.tag_byte    = b;
                        res.header_size = dtlv_pkg::HSIZE_BITS'(1);
                    end
                end
            end
            else
            begin
                case (phase_reg)
                    dtlv_pkg::PH_EXTTAG:
                    begin
                        region_next = region_dec;
                        hc_next     = hc_inc;
                        phase_next  = dtlv_pkg::PH_LENLEAD;
                        if (region_dec == '0)
                        begin
                            phase_next      = dtlv_pkg::PH_IDLE;
                            emit            = 1'b1;
                            res.header_size = hc_inc;
                        end
                    end
                    dtlv_pkg::PH_LENLEAD:
                    begin
                        if (b[7])
                        begin
                            if (lead_n == '0 || lead_n > 7'(MAX_LEN_BYTES))
                            begin
                                phase_next = dtlv_pkg::PH_IDLE;
                                emit       = 1'b1;
                                res.status = dtlv_pkg::ST_BADFORM;
                            end
                            else
                            begin
                                region_next = region_dec;
                                hc_next     = hc_inc;
                                acc_next    = '0;
                                lbl_next    = LBW'(lead_n);
                                phase_next  = dtlv_pkg::PH_LENBYTES;
                                if (region_dec == '0)
                                begin
                                    phase_next      = dtlv_pkg::PH_IDLE;
                                    emit            = 1'b1;
                                    res.header_size = hc_inc;
                                end
                            end
                        end
                        else
                        begin
                            // short form completes the header
                            region_next      = region_dec;
                            hc_next          = hc_inc;
                            acc_next         = dtlv_pkg::LEN_BITS'(b);
                            phase_next       = dtlv_pkg::PH_IDLE;
                            emit             = 1'b1;
                            res.header_size  = hc_inc;
                            res.value_length = dtlv_pkg::LEN_BITS'(b);
                            res.status       = (dtlv_pkg::LEN_BITS'(b) > region_dec) ?
                                               dtlv_pkg::ST_TOOLONG : dtlv_pkg::ST_OK;
                        end
                    end
                    dtlv_pkg::PH_LENBYTES:
                    begin
                        region_next = region_dec;
                        hc_next     = hc_inc;
                        acc_next    = {acc_reg[dtlv_pkg::LEN_BITS-9:0], b};
                        lbl_next    = lbl_reg - 1'b1;
                        if (lbl_reg == LBW'(1))
                        begin
                            phase_next       = dtlv_pkg::PH_IDLE;
                            emit             = 1'b1;
                            res.header_size  = hc_inc;
                            res.value_length = acc_next;
                            res.status       = (acc_next > region_dec) ?
                                               dtlv_pkg::ST_TOOLONG : dtlv_pkg::ST_OK;
                        end
                        else if (region_dec == '0)
                        begin
                            phase_next      = dtlv_pkg::PH_IDLE;
                            emit            = 1'b1;
                            res.header_size = hc_inc;
                        end
                    end
                    default:
                    begin
                        // stray byte while idle is dropped
                        phase_next = phase_reg;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= dtlv_pkg::PH_IDLE;
            tag_reg    <= '0;
            region_reg <= '0;
            acc_reg    <= '0;
            lbl_reg    <= '0;
            hc_reg     <= '0;
        end
        else
        begin
            phase_reg  <= phase_next;
            tag_reg    <= tag_next;
            region_reg <= region_next;
            acc_reg    <= acc_next;
            lbl_reg    <= lbl_next;
            hc_reg     <= hc_next;
        end
    end

endmodule

[sv/dtlv_out_stage.sv]
`timescale 1ns / 1ps

module dtlv_out_stage
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           item_valid,
    input  logic           emit,
    input  dtlv_pkg::res_t res,
    output logic           advance,
    output logic           out_valid,
    input  logic           out_ready,
    output dtlv_pkg::res_t out_res
);

    logic           valid_reg;
    logic           valid_next;
    dtlv_pkg::res_t res_reg;
    logic           out_free;

    // register is free when empty or being taken this cycle
    assign out_free = !valid_reg || out_ready;
    assign advance  = item_valid && out_free;

    always_comb
    begin
        valid_next = valid_reg;
        if (out_free)
        begin
            valid_next = advance && emit;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && emit)
        begin
            res_reg <= res;
        end
    end

    assign out_valid = valid_reg;
    assign out_res   = res_reg;

endmodule

[sv/dtlv_checker.sv]
`timescale 1ns / 1ps

module dtlv_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] value_length,
    input logic [2:0]  header_size,
    input logic [1:0]  status
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    // input only backs up behind a waiting result
    a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input stalled without a pending result");

    a_fail_len: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == dtlv_pkg::ST_TRUNC || status == dtlv_pkg::ST_BADFORM)
        |-> value_length == '0)
        else $error("nonzero length on failed header");

    a_size_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && header_size == '0 |-> status == dtlv_pkg::ST_TRUNC)
        else $error("empty header without truncation");

    // bad lead byte comes after the tag and at most one extra tag byte
    a_badform_size: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == dtlv_pkg::ST_BADFORM
        |-> header_size == 3'd1 || header_size == 3'd2)
        else $error("bad length form at wrong header position");

endmodule

bind der_tlv_header_parser dtlv_checker u_chk
(
    .clk          (clk),
    .rst_n        (rst_n),
    .in_ready     (hdr_bytes.ready),
    .out_valid    (result.valid),
    .out_ready    (result.ready),
    .value_length (result.value_length),
    .header_size  (result.header_size),
    .status       (result.status)
);
